// ===== src/batk_pkg.sv =====
package batk_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ID_BITS     = 24;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int RATE_W      = 16;
  localparam int SCORE_W     = RATE_W + 1;
  localparam int LEN_W       = 16;
  localparam int SLOT_W      = 6;
  localparam int OP_W        = 2;
  localparam int STAT_W      = 3;

  localparam int IN_ID_LSB    = 0;
  localparam int IN_INDEL_LSB = IN_ID_LSB + ID_BITS;
  localparam int IN_MIS_LSB   = IN_INDEL_LSB + RATE_W;
  localparam int IN_LEN_LSB   = IN_MIS_LSB + RATE_W;
  localparam int IN_SLOT_LSB  = IN_LEN_LSB + LEN_W;
  localparam int IN_FIELDS_W  = IN_SLOT_LSB + SLOT_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  localparam int OUT_SLOT_LSB  = 0;
  localparam int OUT_ID_LSB    = OUT_SLOT_LSB + SLOT_W;
  localparam int OUT_SCORE_LSB = OUT_ID_LSB + ID_BITS;
  localparam int OUT_LEN_LSB   = OUT_SCORE_LSB + SCORE_W;
  localparam int OUT_CNT_LSB   = OUT_LEN_LSB + LEN_W;
  localparam int OUT_FIELDS_W  = OUT_CNT_LSB + CNT_W;
  localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_READ   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_APPENDED  = 3'd0,
    STAT_REPLACED  = 3'd1,
    STAT_DISCARDED = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_READ_OK   = 3'd4,
    STAT_CLEARED   = 3'd5,
    STAT_BAD_SLOT  = 3'd6
  } status_e;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [SCORE_W-1:0] score;
    logic [LEN_W-1:0]   len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ===== src/best_alignment_per_key_table_unit.sv =====
// Best-record-per-id alignment table.
// Input stream: tuser carries the operation (insert, read slot, clear); tdata
// carries query id, indel rate, mismatch rate, length and read slot.
// Output stream: one result per insert, read or clear; tuser is the status,
// tdata the slot, stored id, score, length and entry count. Operation code 3
// is dropped without a result.
// Config channel: one bit, append-only mode, written whenever valid is high.
// One item is in flight at a time. Its result is first set in a holding
// register and then loaded into the output register from the emit state. A
// slot read and an insert settled at the last entry first wait for one table
// RAM read; an insert that scans reads the last entry, then up to 64 entries
// from slot 0 on, one table RAM read per cycle. A new item is taken only after
// the result is loaded, so items never overlap in the block.
// While the output register still holds an unaccepted result, a finished
// result waits in the block and no new item is taken.
// Reset empties the table (entry count and largest id go to zero, mode to
// append-off); RAM contents are not cleared.
module best_alignment_per_key_table_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // id, indel_rate, mismatch_rate, align_length, read_slot
  input  logic [batk_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // operation
  input  logic [batk_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // slot, out_query_id, out_score, out_length, entry_count
  output logic [batk_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // status
  output logic [batk_pkg::STAT_W-1:0]     m_axis_tuser,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_data_i
);
  import batk_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAST,
    ST_SCAN,
    ST_READ,
    ST_EMIT
  } state_e;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    entry_t            rec;
    logic [CNT_W-1:0]  count;
  } result_t;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   total_q, total_d;
  logic [ID_BITS-1:0] largest_q, largest_d;
  logic               mode_q;
  entry_t             item_q, item_d;
  logic [ADDR_W-1:0]  scan_q, scan_d;
  result_t            res_q, res_d;
  result_t            out_q;
  logic               m_valid_q;

  entry_t             in_rec, rec_cur, rd_ent;
  op_e                in_op;
  logic [SLOT_W-1:0]  in_slot;
  logic               accept, load_out;
  logic               do_append, set_largest, do_resolve, keep;
  logic [ADDR_W-1:0]  res_slot;

  logic               rd_en, wr_en;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [ENTRY_W-1:0] rd_data;

  assign in_op        = op_e'(s_axis_tuser);
  assign in_slot      = s_axis_tdata[IN_SLOT_LSB +: SLOT_W];
  assign in_rec.id    = s_axis_tdata[IN_ID_LSB +: ID_BITS];
  assign in_rec.score = SCORE_W'(s_axis_tdata[IN_INDEL_LSB +: RATE_W])
                      + SCORE_W'(s_axis_tdata[IN_MIS_LSB +: RATE_W]);
  assign in_rec.len   = s_axis_tdata[IN_LEN_LSB +: LEN_W];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rec_cur       = (state_q == ST_IDLE) ? in_rec : item_q;
  assign rd_ent        = entry_t'(rd_data);
  assign keep          = (rd_ent.score < item_q.score) ||
                         ((rd_ent.score == item_q.score) && (rd_ent.len >= item_q.len));
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    state_d     = state_q;
    total_d     = total_q;
    largest_d   = largest_q;
    item_d      = item_q;
    scan_d      = scan_q;
    res_d       = res_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    do_append   = 1'b0;
    set_largest = 1'b0;
    do_resolve  = 1'b0;
    res_slot    = '0;
    load_out    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            OP_INSERT: begin
              item_d = in_rec;
              if (mode_q || (total_q == '0)) begin
                do_append   = 1'b1;
                set_largest = !mode_q;
              end else begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(total_q - CNT_W'(1));
                state_d = ST_LAST;
              end
            end
            OP_READ: begin
              if (CNT_W'(in_slot) < total_q) begin
                rd_en   = 1'b1;
                rd_addr = ADDR_W'(in_slot);
                scan_d  = ADDR_W'(in_slot);
                state_d = ST_READ;
              end else begin
                res_d.status = STAT_BAD_SLOT;
                res_d.slot   = in_slot;
                res_d.rec    = '0;
                res_d.count  = total_q;
                state_d      = ST_EMIT;
              end
            end
            OP_CLEAR: begin
              total_d      = '0;
              res_d.status = STAT_CLEARED;
              res_d.slot   = '0;
              res_d.rec    = '0;
              res_d.count  = '0;
              state_d      = ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_LAST: begin
        if (rd_ent.id == item_q.id) begin
          do_resolve = 1'b1;
          res_slot   = ADDR_W'(total_q - CNT_W'(1));
        end else if (largest_q >= item_q.id) begin
          rd_en   = 1'b1;
          rd_addr = '0;
          scan_d  = '0;
          state_d = ST_SCAN;
        end else begin
          do_append   = 1'b1;
          set_largest = 1'b1;
        end
      end
      ST_SCAN: begin
        if (rd_ent.id > item_q.id) begin
          do_append = 1'b1;
        end else if (rd_ent.id == item_q.id) begin
          do_resolve = 1'b1;
          res_slot   = scan_q;
        end else if ((CNT_W'(scan_q) + CNT_W'(1)) >= total_q) begin
          do_append = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = scan_q + ADDR_W'(1);
          scan_d  = scan_q + ADDR_W'(1);
        end
      end
      ST_READ: begin
        res_d.status = STAT_READ_OK;
        res_d.slot   = SLOT_W'(scan_q);
        res_d.rec    = rd_ent;
        res_d.count  = total_q;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (do_append) begin
      state_d = ST_EMIT;
      if (total_q >= CNT_W'(MAX_ENTRIES)) begin
        res_d.status = STAT_FULL;
        res_d.slot   = '0;
        res_d.rec    = '0;
        res_d.count  = total_q;
      end else begin
        wr_en        = 1'b1;
        wr_addr      = ADDR_W'(total_q);
        total_d      = total_q + CNT_W'(1);
        if (set_largest) begin
          largest_d = rec_cur.id;
        end
        res_d.status = STAT_APPENDED;
        res_d.slot   = SLOT_W'(total_q);
        res_d.rec    = rec_cur;
        res_d.count  = total_q + CNT_W'(1);
      end
    end

    if (do_resolve) begin
      state_d     = ST_EMIT;
      res_d.slot  = SLOT_W'(res_slot);
      res_d.count = total_q;
      if (keep) begin
        res_d.status = STAT_DISCARDED;
        res_d.rec    = rd_ent;
      end else begin
        wr_en        = 1'b1;
        wr_addr      = res_slot;
        res_d.status = STAT_REPLACED;
        res_d.rec    = item_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      total_q   <= '0;
      largest_q <= '0;
      mode_q    <= 1'b0;
      item_q    <= '0;
      scan_q    <= '0;
      res_q     <= '0;
      out_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      largest_q <= largest_d;
      item_q    <= item_d;
      scan_q    <= scan_d;
      res_q     <= res_d;
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      if (load_out) begin
        out_q     <= res_q;
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  batk_ram #(
    .DEPTH(MAX_ENTRIES),
    .WIDTH(ENTRY_W)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (ENTRY_W'(rec_cur)),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = OUT_TDATA_W'({out_q.count, out_q.rec.len, out_q.rec.score,
                                       out_q.rec.id, out_q.slot});

endmodule

// ===== src/batk_ram.sv =====
module batk_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 57
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ===== src/batk_checker.sv =====
module batk_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [batk_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [batk_pkg::STAT_W-1:0]      m_axis_tuser
);
  import batk_pkg::*;

  logic [SLOT_W-1:0] o_slot;
  logic [CNT_W-1:0]  o_count;

  assign o_slot  = m_axis_tdata[OUT_SLOT_LSB +: SLOT_W];
  assign o_count = m_axis_tdata[OUT_CNT_LSB +: CNT_W];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_append_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STAT_APPENDED) |->
      (CNT_W'(o_slot) + CNT_W'(1)) == o_count)
    else $error("appended slot is not the last entry");

  a_hit_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && ((m_axis_tuser == STAT_REPLACED) ||
                      (m_axis_tuser == STAT_DISCARDED) ||
                      (m_axis_tuser == STAT_READ_OK)) |->
      CNT_W'(o_slot) < o_count)
    else $error("slot outside valid entries");

  a_bad_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STAT_BAD_SLOT) |-> CNT_W'(o_slot) >= o_count)
    else $error("bad slot reported for a valid entry");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STAT_CLEARED) |-> (m_axis_tdata == '0))
    else $error("clear result not empty");

endmodule

bind best_alignment_per_key_table_unit batk_checker u_batk_checker (.*);

// ===== verif/alignment_table_checker.sv =====
module alignment_table_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_valid_i,
  input  logic                             s_ready_i,
  input  logic [batk_pkg::IN_TDATA_W-1:0]  s_data_i,
  input  logic [batk_pkg::OP_W-1:0]        s_user_i,
  input  logic                             m_valid_i,
  input  logic                             m_ready_i,
  input  logic [batk_pkg::OUT_TDATA_W-1:0] m_data_i,
  input  logic [batk_pkg::STAT_W-1:0]      m_user_i,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic                             cfg_data_i,
  output int                               errors_o,
  output int                               pending_o
);
  import batk_pkg::*;

  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [ID_BITS-1:0] id;
    logic [SCORE_W-1:0] score;
    logic [LEN_W-1:0]   len;
    logic [CNT_W-1:0]   count;
  } table_reply_t;

  entry_t             rec_mem [MAX_ENTRIES];
  int                 rec_count;
  logic [ID_BITS-1:0] top_id;
  logic               append_only;
  table_reply_t       pending_replies [$];

  initial begin
    errors_o  = 0;
    pending_o = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] table checker: %s", $time, msg);
    errors_o++;
  endtask

  task automatic compare_field(input string name, input longint got, input longint want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  function automatic void queue_reply(table_reply_t r);
    pending_replies = {pending_replies, r};
  endfunction

  function automatic table_reply_t slot_view(status_e st, int idx);
    table_reply_t r;
    r.status = st;
    r.slot   = SLOT_W'(idx);
    r.id     = rec_mem[idx].id;
    r.score  = rec_mem[idx].score;
    r.len    = rec_mem[idx].len;
    r.count  = CNT_W'(rec_count);
    return r;
  endfunction

  function automatic table_reply_t blank_view(status_e st, logic [SLOT_W-1:0] s);
    table_reply_t r;
    r        = '0;
    r.status = st;
    r.slot   = s;
    r.count  = CNT_W'(rec_count);
    return r;
  endfunction

  function automatic table_reply_t add_record(entry_t rec, bit bump);
    if (rec_count >= MAX_ENTRIES) return blank_view(STAT_FULL, '0);
    rec_mem[rec_count] = rec;
    rec_count++;
    if (bump) top_id = rec.id;
    return slot_view(STAT_APPENDED, rec_count - 1);
  endfunction

  // stored record wins on lower score, or equal score and no shorter length
  function automatic table_reply_t merge_record(entry_t rec, int idx);
    logic keep;
    keep = (rec_mem[idx].score < rec.score) ||
           (rec_mem[idx].score == rec.score && rec_mem[idx].len >= rec.len);
    if (keep) return slot_view(STAT_DISCARDED, idx);
    rec_mem[idx] = rec;
    return slot_view(STAT_REPLACED, idx);
  endfunction

  function automatic table_reply_t apply_insert(entry_t rec);
    if (append_only) return add_record(rec, 1'b0);
    if (rec_count == 0) return add_record(rec, 1'b1);
    if (rec_mem[rec_count-1].id == rec.id) return merge_record(rec, rec_count - 1);
    if (top_id < rec.id) return add_record(rec, 1'b1);
    for (int i = 0; i < rec_count; i++) begin
      if (rec_mem[i].id > rec.id) break;
      if (rec_mem[i].id == rec.id) return merge_record(rec, i);
    end
    return add_record(rec, 1'b0);
  endfunction

  task automatic check_reply(input table_reply_t want);
    compare_field("status", m_user_i, want.status);
    compare_field("slot", m_data_i[OUT_SLOT_LSB +: SLOT_W], want.slot);
    compare_field("query id", m_data_i[OUT_ID_LSB +: ID_BITS], want.id);
    compare_field("score", m_data_i[OUT_SCORE_LSB +: SCORE_W], want.score);
    compare_field("length", m_data_i[OUT_LEN_LSB +: LEN_W], want.len);
    compare_field("entry count", m_data_i[OUT_CNT_LSB +: CNT_W], want.count);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    entry_t            rec;
    logic [SLOT_W-1:0] rs;
    if (!rst_ni) begin
      rec_count   = 0;
      top_id      = '0;
      append_only = 1'b0;
      pending_replies.delete();
      pending_o   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) append_only = cfg_data_i;
      if (m_valid_i && m_ready_i) begin
        if (pending_replies.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, status %0d", m_user_i));
        end else begin
          check_reply(pending_replies.pop_front());
        end
      end
      if (s_valid_i && s_ready_i) begin
        rs = s_data_i[IN_SLOT_LSB +: SLOT_W];
        case (s_user_i)
          OP_INSERT: begin
            rec.id    = s_data_i[IN_ID_LSB +: ID_BITS];
            rec.score = SCORE_W'(s_data_i[IN_INDEL_LSB +: RATE_W]) +
                        SCORE_W'(s_data_i[IN_MIS_LSB +: RATE_W]);
            rec.len   = s_data_i[IN_LEN_LSB +: LEN_W];
            queue_reply(apply_insert(rec));
          end
          OP_READ: begin
            if (rs < rec_count) queue_reply(slot_view(STAT_READ_OK, rs));
            else queue_reply(blank_view(STAT_BAD_SLOT, rs));
          end
          OP_CLEAR: begin
            rec_count = 0;
            queue_reply(blank_view(STAT_CLEARED, '0));
          end
          default: ;
        endcase
      end
      pending_o = pending_replies.size();
    end
  end

endmodule

// ===== verif/tb_best_alignment_per_key_table_unit.sv =====
module tb_best_alignment_per_key_table_unit;
  import batk_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 80;
  localparam int LONG_HOLD = 300;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]        s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [STAT_W-1:0]      m_axis_tuser;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic                   cfg_data_i;

  int                 errors;
  int                 pending;
  int                 quiet = 0;
  bit                 src_idle_en;
  bit                 sink_idle_en;
  bit                 hold_req;
  logic [ID_BITS-1:0] last_id;

  best_alignment_per_key_table_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  alignment_table_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_i   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .m_valid_i   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_i    (m_axis_tdata),
    .m_user_i    (m_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    wait (quiet >= STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  // result sink: random stalls, plus one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  function automatic logic [RATE_W-1:0] pick_rate();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return RATE_W'($urandom_range(0, 3) * 64);
      default: return RATE_W'($urandom);
    endcase
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return LEN_W'($urandom_range(20, 23));
      default: return LEN_W'($urandom);
    endcase
  endfunction

  task automatic send_op(input logic [OP_W-1:0] op, input logic [ID_BITS-1:0] id,
                         input logic [RATE_W-1:0] indel, input logic [RATE_W-1:0] mis,
                         input logic [LEN_W-1:0] len, input logic [SLOT_W-1:0] rs);
    logic [IN_TDATA_W-1:0] word;
    word = '0;
    word[IN_ID_LSB +: ID_BITS]   = id;
    word[IN_INDEL_LSB +: RATE_W] = indel;
    word[IN_MIS_LSB +: RATE_W]   = mis;
    word[IN_LEN_LSB +: LEN_W]    = len;
    word[IN_SLOT_LSB +: SLOT_W]  = rs;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic insert_rec(input logic [ID_BITS-1:0] id, input logic [RATE_W-1:0] indel,
                            input logic [RATE_W-1:0] mis, input logic [LEN_W-1:0] len);
    send_op(OP_INSERT, id, indel, mis, len, SLOT_W'($urandom));
  endtask

  task automatic read_at(input logic [SLOT_W-1:0] rs);
    send_op(OP_READ, ID_BITS'($urandom), RATE_W'($urandom), RATE_W'($urandom),
            LEN_W'($urandom), rs);
  endtask

  task automatic clear_table();
    send_op(OP_CLEAR, ID_BITS'($urandom), RATE_W'($urandom), RATE_W'($urandom),
            LEN_W'($urandom), SLOT_W'($urandom));
  endtask

  // stop the source, wait until every result is back, then let the bench idle before going on
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic append_only);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= append_only;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly ascending ids with repeats and revisits, some noise
  task automatic run_random(input int n, input int clr_pct);
    int                 done;
    int                 roll;
    logic [ID_BITS-1:0] id;
    done = 0;
    while (done < n) begin
      roll = $urandom_range(0, 99);
      if (roll < clr_pct) begin
        clear_table();
      end else if (roll < clr_pct + 8) begin
        read_at(SLOT_W'($urandom_range(0, 63)));
      end else if (roll < clr_pct + 10) begin
        send_op(OP_RESERVED, ID_BITS'($urandom), pick_rate(), pick_rate(), pick_len(),
                SLOT_W'($urandom));
        continue;
      end else begin
        if (roll < 45) begin
          id = last_id;
        end else if (roll < 70) begin
          last_id = last_id + ID_BITS'($urandom_range(1, 4));
          id = last_id;
        end else if (roll < 92) begin
          id = last_id - ID_BITS'($urandom_range(1, 12));
        end else begin
          id = ID_BITS'($urandom);
        end
        insert_rec(id, pick_rate(), pick_rate(), pick_len());
      end
      done++;
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_INSERT;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= 1'b0;
    src_idle_en   = 1'b1;
    sink_idle_en  = 1'b1;
    hold_req      = 1'b0;
    last_id       = 24'd7;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_mode(1'b0);
    read_at(6'd0);
    insert_rec(24'd100, 16'd10, 16'd10, 16'd50);
    insert_rec(24'd100, 16'd20, 16'd20, 16'd50);
    insert_rec(24'd100, 16'd5, 16'd5, 16'd40);
    insert_rec(24'd100, 16'd5, 16'd5, 16'd40);
    insert_rec(24'd100, 16'd0, 16'd10, 16'd41);
    insert_rec(24'd100, 16'd2, 16'd8, 16'd30);
    insert_rec(24'd200, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    insert_rec(24'd100, 16'd0, 16'd0, 16'd0);
    insert_rec(24'd150, 16'd300, 16'd1, 16'd9);
    insert_rec(24'd0, 16'd0, 16'd0, 16'd0);
    insert_rec(24'hFFFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    insert_rec(24'd150, 16'd1, 16'd1, 16'd9);
    read_at(6'd0);
    read_at(6'd5);
    read_at(6'd6);
    read_at(6'd63);
    send_op(OP_RESERVED, 24'd5, 16'd1, 16'd1, 16'd1, 6'd1);
    clear_table();
    read_at(6'd0);
    insert_rec(24'd7, 16'd100, 16'd100, 16'd10);
    insert_rec(24'd3, 16'd50, 16'd50, 16'd10);
    insert_rec(24'd7, 16'd200, 16'd200, 16'd10);

    set_mode(1'b1);
    run_random(150, 1);
    set_mode(1'b0);
    run_random(120, 1);
    hold_req = 1'b1;
    run_random(130, 1);
    set_mode(1'b1);
    run_random(60, 2);
    set_mode(1'b0);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    run_random(110, 1);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
